// ===== design/sfd_pkg.sv =====
// Shared types, constants and cosine table builder for the stereo flanger delay.
// No dependencies; used by sfd_mod_unit and stereo_flanger_delay.
package sfd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CURSOR_W   = 10;
    localparam int DIV_W      = 11;
    localparam int COS_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int PHASE_W    = 32;
    localparam int DEPTH_W    = 9;
    localparam int GAIN_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN   = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd89478;
    localparam logic [DEPTH_W-1:0] HALF_DEPTH_RST = 9'd24;
    localparam logic [GAIN_W-1:0]  WET_GAIN_RST   = 17'd32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } mod_req_t;

    // cos(pi/2 * x), x in Q15 over 0..32768, result Q15
    function automatic longint quarter_cos(longint x);
        longint t;
        longint r;
        t = x * x;
        r = 64'sd987047;
        r = 64'sd22401998 - ((r * t) >>> 30);
        r = 64'sd272375559 - ((r * t) >>> 30);
        r = 64'sd1324675879 - ((r * t) >>> 30);
        r = 64'sd1073741824 - ((r * t) >>> 30);
        if (r < 0) begin
            r = 0;
        end
        r = (r + 64'sd16384) >>> 15;
        if (r > 64'sd32768) begin
            r = 64'sd32768;
        end
        return r;
    endfunction

    function automatic logic signed [COS_W-1:0] cos_entry(int k, int bits);
        int     qb;
        int     quad;
        longint x;
        longint c;
        qb   = bits - 2;
        x    = longint'(k & ((1 << qb) - 1)) << (15 - qb);
        quad = (k >> qb) & 3;
        case (quad)
            0: begin
                c = quarter_cos(x);
            end
            1: begin
                c = -quarter_cos(64'sd32768 - x);
            end
            2: begin
                c = -quarter_cos(x);
            end
            default: begin
                c = quarter_cos(64'sd32768 - x);
            end
        endcase
        return COS_W'(c);
    endfunction

endpackage

// ===== design/sfd_mod_unit.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on sfd_pkg for widths and the request struct.
module sfd_mod_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sfd_pkg::mod_req_t           req,
    output logic                        done,
    output logic [sfd_pkg::DIV_W-1:0]   rem
);

    localparam int W     = sfd_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       trial;

    assign trial = {rem_reg, dvd_reg[W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/stereo_flanger_delay.sv =====
// Top level of the stereo flanger: LFO-modulated delay line over a frame store.
// Depends on sfd_pkg and sfd_mod_unit.
// Usage:
//   s_valid/s_ready/s_data carry one stereo frame per beat (Q1.15 samples).
//   m_valid/m_ready/m_data carry one output frame per input beat, in order.
//   cfg_wr_en/cfg_index/cfg_wr_data write phase_step (0), half_depth (1) and
//   wet_gain (2); other indexes are ignored. Write only while the block is idle.
// Sequence:
//   The result beat is loaded in the sum state, after the address, store read
//   and mix states. A store under 1024 frames stays in the address state for
//   each subtraction of STORE_FRAMES from the cursor. The cursor then wraps in
//   the remainder unit; s_ready returns only when the remainder is done, so a
//   new frame is not accepted until the last one is through.
// Reset:
//   aresetn restores the register defaults, zeroes phase and cursor, and empties
//   the store through a fill count: entries at or above it read as silence.
// Stall:
//   A result waits in the output register until m_ready; the next frame may be
//   accepted meanwhile and holds before its own result until the register frees.
module stereo_flanger_delay #(
    parameter int STORE_FRAMES   = 1024,
    parameter int CHANNEL_COUNT  = 2,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sfd_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sfd_pkg::out_t                       m_data,
    input  logic                                cfg_wr_en,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int SW       = sfd_pkg::SAMPLE_W;
    localparam int DW       = sfd_pkg::DIV_W;
    localparam int CW       = sfd_pkg::CURSOR_W;
    localparam int ADDR_W   = $clog2(STORE_FRAMES);
    localparam int FILL_W   = $clog2(STORE_FRAMES + 1);
    localparam int MEM_W    = SW * CHANNEL_COUNT;
    localparam int COS_SIZE = 1 << COS_TABLE_BITS;
    localparam int ADDR_DIV = (STORE_FRAMES > 1023) ? 1024 : STORE_FRAMES;
    localparam logic [CW:0] ADDR_MOD = (CW+1)'(ADDR_DIV);
    localparam int PROD_W   = SW + sfd_pkg::GAIN_W + 1;
    localparam int DP_W     = sfd_pkg::COS_W + sfd_pkg::DEPTH_W + 1;
    localparam int LEN_W    = sfd_pkg::DEPTH_W + 3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADDR = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_MIX  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_WRAP = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [sfd_pkg::PHASE_W-1:0]  phase_step_reg;
    logic [sfd_pkg::DEPTH_W-1:0]  half_depth_reg;
    logic [sfd_pkg::GAIN_W-1:0]   wet_gain_reg;
    logic [sfd_pkg::PHASE_W-1:0]  phase_reg;
    logic [CW-1:0]                cursor_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [CW-1:0]                addr_work_reg;
    logic                         addr_more;
    sfd_pkg::in_t                 in_reg;
    logic                         m_valid_reg;
    sfd_pkg::out_t                m_data_reg;

    logic [MEM_W-1:0]             store_mem [STORE_FRAMES];
    logic [MEM_W-1:0]             rd_data_reg;
    logic [MEM_W-1:0]             wr_word;
    logic                         mem_we;
    logic                         entry_valid;

    logic signed [sfd_pkg::COS_W-1:0] cos_lut [COS_SIZE];
    logic signed [sfd_pkg::COS_W-1:0] cos_reg;
    logic signed [DP_W-1:0]           dp_reg;
    logic signed [DP_W-1:0]           dp_round;
    logic signed [LEN_W-1:0]          tq;
    logic signed [LEN_W-1:0]          len_raw;
    logic [DW-1:0]                    len_val;

    sfd_pkg::mod_req_t            mod_req;
    logic                         mod_done;
    logic [DW-1:0]                mod_rem;

    logic                         s_accept;
    logic                         out_free;
    logic signed [SW-1:0]         in_lane [2];
    logic signed [SW-1:0]         y_lane  [2];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mem_we   = (state_reg == ST_SUM) && out_free;
    assign addr_more = ({1'b0, addr_work_reg} >= ADDR_MOD);

    assign in_lane[0] = in_reg.sample_left;
    assign in_lane[1] = in_reg.sample_right;

    for (genvar k = 0; k < COS_SIZE; k++) begin : g_cos
        assign cos_lut[k] = sfd_pkg::cos_entry(k, COS_TABLE_BITS);
    end

    // loop length from the registered depth product
    assign dp_round = (dp_reg < 0) ? (dp_reg + DP_W'(32767)) : dp_reg;
    assign tq       = LEN_W'(dp_round >>> 15);
    assign len_raw  = $signed({3'b000, half_depth_reg}) - tq;
    assign len_val  = (len_raw <= 0) ? DW'(1) : DW'(len_raw);

    always_comb begin
        mod_req.start    = mem_we;
        mod_req.dividend = DW'({1'b0, cursor_reg} + 1'b1);
        mod_req.divisor  = len_val;
    end

    sfd_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                if (!addr_more) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_MIX;
            end
            ST_MIX: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (mod_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_step_reg <= sfd_pkg::PHASE_STEP_RST;
            half_depth_reg <= sfd_pkg::HALF_DEPTH_RST;
            wet_gain_reg   <= sfd_pkg::WET_GAIN_RST;
            phase_reg      <= '0;
            cursor_reg     <= '0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    sfd_pkg::CFG_PHASE_STEP: begin
                        phase_step_reg <= cfg_wr_data;
                    end
                    sfd_pkg::CFG_HALF_DEPTH: begin
                        half_depth_reg <= cfg_wr_data[sfd_pkg::DEPTH_W-1:0];
                    end
                    sfd_pkg::CFG_WET_GAIN: begin
                        wet_gain_reg <= cfg_wr_data[sfd_pkg::GAIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if ((state_reg == ST_ADDR) && !addr_more) begin
                phase_reg <= phase_reg + phase_step_reg;
            end
            if ((state_reg == ST_WRAP) && mod_done) begin
                cursor_reg <= CW'(mod_rem);
            end
            if (mem_we && (FILL_W'(addr_reg) == fill_reg)) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (mem_we) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
        if (s_accept) begin
            addr_work_reg <= cursor_reg;
        end else if ((state_reg == ST_ADDR) && addr_more) begin
            addr_work_reg <= CW'({1'b0, addr_work_reg} - ADDR_MOD);
        end
        if ((state_reg == ST_ADDR) && !addr_more) begin
            addr_reg <= ADDR_W'(addr_work_reg);
        end
        cos_reg <= cos_lut[phase_reg[sfd_pkg::PHASE_W-1 -: COS_TABLE_BITS]];
        if (state_reg == ST_MIX) begin
            dp_reg <= cos_reg * $signed({1'b0, half_depth_reg});
        end
        if (mem_we) begin
            m_data_reg.out_left  <= y_lane[0];
            m_data_reg.out_right <= y_lane[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[addr_reg] <= wr_word;
        end
        rd_data_reg <= store_mem[addr_reg];
    end

    assign entry_valid = (FILL_W'(addr_reg) < fill_reg);

    for (genvar ch = 0; ch < 2; ch++) begin : g_lane
        if (ch < CHANNEL_COUNT) begin : g_on
            logic signed [SW-1:0]     stored;
            logic signed [PROD_W-1:0] prod_reg;
            logic signed [PROD_W-17:0] scaled;
            logic signed [PROD_W-15:0] sum;

            assign stored = entry_valid ? $signed(rd_data_reg[SW*ch +: SW]) : '0;
            assign scaled = prod_reg[PROD_W-1:16];
            assign sum    = $signed({{2{scaled[PROD_W-17]}}, scaled})
                          + $signed({{(PROD_W-14-SW){in_lane[ch][SW-1]}}, in_lane[ch]});
            assign wr_word[SW*ch +: SW] = in_lane[ch];

            always_ff @(posedge aclk) begin
                if (state_reg == ST_MIX) begin
                    prod_reg <= stored * $signed({1'b0, wet_gain_reg});
                end
            end

            always_comb begin
                if (sum > $signed((PROD_W-14)'(32767))) begin
                    y_lane[ch] = 16'sh7fff;
                end else if (sum < -$signed((PROD_W-14)'(32768))) begin
                    y_lane[ch] = 16'sh8000;
                end else begin
                    y_lane[ch] = SW'(sum);
                end
            end
        end else begin : g_off
            assign y_lane[ch] = '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stereo_flanger_delay: directed and random stereo frames
// go through a bursty valid/ready driver, and each result beat is checked in order.
// Depends on sfd_pkg and the stereo_flanger_delay RTL; carries its own delay-line predictor.
module tb;

    localparam int SAMPLE_W    = sfd_pkg::SAMPLE_W;
    localparam int CURSOR_W    = sfd_pkg::CURSOR_W;
    localparam int PHASE_W     = sfd_pkg::PHASE_W;
    localparam int DEPTH_W     = sfd_pkg::DEPTH_W;
    localparam int GAIN_W      = sfd_pkg::GAIN_W;
    localparam int CFG_IDX_W   = sfd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = sfd_pkg::CFG_DATA_W;

    localparam int FRAMES      = 1024;
    localparam int COS_ENTRIES = 256;
    localparam int QUAD_SIZE   = 64;
    localparam int WATCHDOG    = 2000;
    localparam int SETTLE      = 40;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } stall_e;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sfd_pkg::in_t          s_data;
    logic                  m_valid;
    logic                  m_ready;
    sfd_pkg::out_t         m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // predictor state
    logic [PHASE_W-1:0]  step_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [PHASE_W-1:0]  lfo_acc;
    logic [CURSOR_W-1:0] tap;
    logic [CURSOR_W-1:0] span;
    logic [31:0]         delay_mem [FRAMES];
    longint              cos_q15 [COS_ENTRIES];

    sfd_pkg::in_t    frame_queue [$];
    sfd_pkg::out_t   flange_expect [$];

    int     frames_sent;
    int     frames_taken;
    int     results_seen;
    int     mismatches;
    int     settings;
    int     longest_loop;
    int     idle_cycles;
    int     burst_left;
    int     gap_left;
    int     stall_tick;
    stall_e stall_mode;

    stereo_flanger_delay dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cos(pi/2 * x) for x in Q15, result in Q15
    function automatic longint quarter_wave(longint x);
        longint t2;
        longint acc;
        t2  = x * x;
        acc = 987047;
        acc = 22401998 - ((acc * t2) >>> 30);
        acc = 272375559 - ((acc * t2) >>> 30);
        acc = 1324675879 - ((acc * t2) >>> 30);
        acc = 1073741824 - ((acc * t2) >>> 30);
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > 32768) begin
            acc = 32768;
        end
        return acc;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] wet_sum(logic signed [SAMPLE_W-1:0] held,
                                                           logic signed [SAMPLE_W-1:0] dry);
        longint prod;
        longint total;
        prod  = longint'(held) * longint'(gain_reg);
        total = (prod >>> 16) + longint'(dry);
        if (total > 32767) begin
            total = 32767;
        end
        if (total < -32768) begin
            total = -32768;
        end
        return total[SAMPLE_W-1:0];
    endfunction

    function automatic sfd_pkg::out_t flange_step(sfd_pkg::in_t frame);
        sfd_pkg::out_t res;
        logic [31:0]   word;
        longint        c;
        longint        m;
        longint        tr;
        longint        len;
        word          = delay_mem[tap];
        res.out_left  = wet_sum(word[15:0], frame.sample_left);
        res.out_right = wet_sum(word[31:16], frame.sample_right);
        delay_mem[tap] = {frame.sample_right, frame.sample_left};
        lfo_acc = lfo_acc + step_reg;
        c   = cos_q15[lfo_acc[31:24]];
        m   = -(c * longint'(depth_reg));
        tr  = (m >= 0) ? (m >>> 15) : -((-m) >>> 15);
        len = longint'(depth_reg) + tr;
        span = (len <= 0) ? CURSOR_W'(1) : len[CURSOR_W-1:0];
        if (span == 0) begin
            span = CURSOR_W'(1);
        end
        if (int'(span) > longest_loop) begin
            longest_loop = int'(span);
        end
        tap = CURSOR_W'((tap + 1) % span);
        return res;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            sfd_pkg::CFG_PHASE_STEP: begin
                step_reg = val;
            end
            sfd_pkg::CFG_HALF_DEPTH: begin
                depth_reg = val[DEPTH_W-1:0];
            end
            sfd_pkg::CFG_WET_GAIN: begin
                gain_reg = val[GAIN_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_config(logic [31:0] step_val, logic [31:0] depth_val,
                              logic [31:0] gain_val);
        write_reg(sfd_pkg::CFG_PHASE_STEP, step_val);
        write_reg(sfd_pkg::CFG_HALF_DEPTH, depth_val);
        write_reg(sfd_pkg::CFG_WET_GAIN, gain_val);
        settings++;
    endtask

    task automatic queue_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
        sfd_pkg::in_t f;
        f.sample_left  = l;
        f.sample_right = r;
        frame_queue.push_back(f);
    endtask

    // hold until every queued frame has produced its result and the block is idle
    task automatic drain();
        while (frame_queue.size() != 0 || results_seen < frames_sent || !s_ready) begin
            @(negedge aclk);
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                return 16'sh7fff;
            end
            1: begin
                return 16'sh8000;
            end
            2: begin
                return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            end
            default: begin
                return SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    initial begin : stimulus
        longint      x;
        logic [31:0] step_pick;
        logic [31:0] depth_pick;
        logic [31:0] gain_pick;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        for (int k = 0; k < COS_ENTRIES; k++) begin
            x = longint'(k % QUAD_SIZE) * 512;
            case (k / QUAD_SIZE)
                0: begin
                    cos_q15[k] = quarter_wave(x);
                end
                1: begin
                    cos_q15[k] = -quarter_wave(32768 - x);
                end
                2: begin
                    cos_q15[k] = -quarter_wave(x);
                end
                default: begin
                    cos_q15[k] = quarter_wave(32768 - x);
                end
            endcase
        end
        for (int k = 0; k < FRAMES; k++) begin
            delay_mem[k] = '0;
        end
        step_reg     = sfd_pkg::PHASE_STEP_RST;
        depth_reg    = sfd_pkg::HALF_DEPTH_RST;
        gain_reg     = sfd_pkg::WET_GAIN_RST;
        lfo_acc      = '0;
        tap          = '0;
        span         = CURSOR_W'(1);
        longest_loop = 1;
        settings     = 1;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: half gain on a one-frame loop
        queue_frame(16'sh7fff, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7fff);
        queue_frame(16'sh7fff, 16'sh7fff);
        queue_frame(16'sh8000, 16'sh8000);
        queue_frame(16'sh0000, 16'sh0000);
        queue_frame(16'sh0001, -16'sh0001);
        drain();

        // maximum gain, zero depth, frozen phase; stray index must not land anywhere
        set_config(32'h0, 32'd0, 32'd131071);
        write_reg(CFG_UNUSED, 32'h0);
        queue_frame(16'sh7fff, 16'sh8000);
        queue_frame(16'sh7fff, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7fff);
        queue_frame(-16'sh0001, 16'sh0001);
        drain();

        // half-turn steps swing the loop between 1022 frames and 1
        set_config(32'h8000_0000, 32'd511, 32'd65536);
        queue_frame(16'sh1234, -16'sh4321);
        queue_frame(16'sh7fff, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7fff);
        queue_frame(16'sh0555, 16'sh2aaa);
        queue_frame(-16'sh7000, 16'sh7000);
        queue_frame(16'sh0000, 16'sh0001);
        drain();

        // dry signal only
        set_config(32'hffff_ffff, 32'd1, 32'd0);
        queue_frame(16'sh7fff, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7fff);
        queue_frame(16'sh5a5a, -16'sh5a5a);
        queue_frame(16'sh0000, 16'sh0000);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0: begin
                    step_pick = '0;
                end
                1: begin
                    step_pick = '1;
                end
                2: begin
                    step_pick = 32'h8000_0000;
                end
                3: begin
                    step_pick = 32'h0100_0000;
                end
                4: begin
                    step_pick = sfd_pkg::PHASE_STEP_RST;
                end
                5: begin
                    step_pick = $urandom;
                end
                default: begin
                    step_pick = $urandom_range(32'h0040_0000, 32'h0400_0000);
                end
            endcase
            case ($urandom_range(0, 6))
                0: begin
                    depth_pick = 0;
                end
                1: begin
                    depth_pick = 1;
                end
                2: begin
                    depth_pick = 511;
                end
                3: begin
                    depth_pick = 32'(sfd_pkg::HALF_DEPTH_RST);
                end
                default: begin
                    depth_pick = $urandom_range(16, 511);
                end
            endcase
            case ($urandom_range(0, 6))
                0: begin
                    gain_pick = 0;
                end
                1: begin
                    gain_pick = 1;
                end
                2: begin
                    gain_pick = 65536;
                end
                3: begin
                    gain_pick = 131071;
                end
                4: begin
                    gain_pick = 32'(sfd_pkg::WET_GAIN_RST);
                end
                default: begin
                    gain_pick = $urandom_range(0, 131071);
                end
            endcase
            set_config(step_pick, depth_pick, gain_pick);
            if (ph == 0) begin
                write_reg(CFG_UNUSED, $urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_frame(pick_sample(), pick_sample());
            end
            drain();
        end

        drain();
        repeat (SETTLE) @(negedge aclk);
        $display("covered %0d frames under %0d register settings, %0d results checked",
                 frames_sent, settings, results_seen);
        $display("longest modeled loop %0d frames", longest_loop);
        if (mismatches == 0 && flange_expect.size() == 0) begin
            $display("[stereo_flanger_delay] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, flange_expect.size());
            $display("[stereo_flanger_delay] ERROR");
        end
        $finish;
    end

    // sender: bursts of frames with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || frames_taken == frames_sent) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (frame_queue.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_data  <= frame_queue.pop_front();
                s_valid <= 1'b1;
                frames_sent++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // receiver: stall pattern drawn at random from four modes
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall_tick++;
            if (stall_tick % 97 == 0) begin
                stall_mode = stall_e'($urandom_range(0, 3));
            end
            case (stall_mode)
                READY_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                READY_MOSTLY: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                READY_RARELY: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= ((stall_tick % 11) < 5);
                end
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        sfd_pkg::out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                flange_expect.push_back(flange_step(s_data));
                frames_taken++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (flange_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result beat %0d with nothing expected: l=%0d r=%0d",
                                 results_seen, m_data.out_left, m_data.out_right);
                    end
                end else begin
                    want = flange_expect.pop_front();
                    if (m_data.out_left !== want.out_left
                            || m_data.out_right !== want.out_right) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("beat %0d: expected l=%0d r=%0d, got l=%0d r=%0d",
                                     results_seen, want.out_left, want.out_right,
                                     m_data.out_left, m_data.out_right);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("timeout: no beat for %0d cycles", idle_cycles);
            $display("[stereo_flanger_delay] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
